/* rtl/ecl_pkg.sv */
// ----------------------------------------------------------------------------
// ecl_pkg
// Shared types and constants of the escape and comment lexer.
// ----------------------------------------------------------------------------
package ecl_pkg;

  typedef enum logic [3:0] {
    M_OUT       = 4'd0,
    M_SLASH     = 4'd1,
    M_BLOCK     = 4'd2,
    M_BLOCK_STAR= 4'd3,
    M_LINE      = 4'd4,
    M_STR       = 4'd5,
    M_ESC       = 4'd6,
    M_OCT       = 4'd7,
    M_HEX       = 4'd8
  } lex_mode_t;

  localparam logic [2:0] K_CHAR   = 3'd0;
  localparam logic [2:0] K_SSTART = 3'd1;
  localparam logic [2:0] K_SBYTE  = 3'd2;
  localparam logic [2:0] K_SEND   = 3'd3;
  localparam logic [2:0] K_ERR    = 3'd4;
  localparam logic [2:0] K_END    = 3'd5;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_3     = 8'h33;
  localparam logic [7:0] CH_7     = 8'h37;

  // Up to three results caused by one request.
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][2:0] kind;
    logic [2:0][7:0] value;
  } ecl_bundle_t;

endpackage

/* rtl/ecl_front.sv */
// ----------------------------------------------------------------------------
// ecl_front
// Lexer FSM: takes one byte per cycle unless q_full; builds its result bundle.
// ----------------------------------------------------------------------------
module ecl_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,
  input  logic                 in_tuser,
  input  logic                 q_full,
  output logic                 q_push,
  output ecl_pkg::ecl_bundle_t q_bundle
);

  ecl_pkg::lex_mode_t mode_r, mode_nxt;
  logic [7:0]         dv_r, dv_nxt;
  logic [1:0]         dc_r, dc_nxt;
  logic               so_r, so_nxt;
  logic               accept;

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, c[3:0]};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c[3:0] + 4'd9)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c[3:0] + 4'd9)};
    return r;
  endfunction

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    logic [7:0]      c;
    logic [1:0]      n;
    logic [2:0][2:0] kv;
    logic [2:0][7:0] vv;
    logic            do_out;
    logic            do_str;
    logic [1:0]      limit;
    logic [1:0]      cnt_inc;
    logic [7:0]      acc;
    logic [4:0]      h;
    c        = in_tdata;
    n        = 2'd0;
    kv       = '0;
    vv       = '0;
    do_out   = 1'b0;
    do_str   = 1'b0;
    mode_nxt = mode_r;
    dv_nxt   = dv_r;
    dc_nxt   = dc_r;
    so_nxt   = so_r;
    limit    = so_r ? 2'd2 : 2'd3;
    cnt_inc  = 2'(dc_r + 2'd1);
    h        = hex_val(c);
    acc      = 8'h00;
    if (in_tuser) begin
      case (mode_r)
        ecl_pkg::M_SLASH: begin
          kv[n] = ecl_pkg::K_CHAR; vv[n] = ecl_pkg::CH_SLASH; n = 2'(n + 2'd1);
          kv[n] = ecl_pkg::K_END; n = 2'(n + 2'd1);
        end
        ecl_pkg::M_STR: begin
          kv[n] = ecl_pkg::K_ERR; n = 2'(n + 2'd1);
        end
        ecl_pkg::M_ESC: begin
          kv[n] = ecl_pkg::K_SBYTE; vv[n] = ecl_pkg::CH_BSL; n = 2'(n + 2'd1);
          kv[n] = ecl_pkg::K_ERR; n = 2'(n + 2'd1);
        end
        ecl_pkg::M_OCT: begin
          kv[n] = ecl_pkg::K_SBYTE; vv[n] = dv_r; n = 2'(n + 2'd1);
          kv[n] = ecl_pkg::K_ERR; n = 2'(n + 2'd1);
        end
        ecl_pkg::M_HEX: begin
          if (dc_r == 2'd0) begin
            kv[n] = ecl_pkg::K_SBYTE; vv[n] = ecl_pkg::CH_BSL; n = 2'(n + 2'd1);
            kv[n] = ecl_pkg::K_SBYTE; vv[n] = ecl_pkg::CH_X; n = 2'(n + 2'd1);
          end else begin
            kv[n] = ecl_pkg::K_SBYTE; vv[n] = dv_r; n = 2'(n + 2'd1);
          end
          kv[n] = ecl_pkg::K_ERR; n = 2'(n + 2'd1);
        end
        default: begin
          kv[n] = ecl_pkg::K_END; n = 2'(n + 2'd1);
        end
      endcase
      mode_nxt = ecl_pkg::M_OUT;
      dv_nxt   = 8'h00;
      dc_nxt   = 2'd0;
      so_nxt   = 1'b0;
    end else begin
      case (mode_r)
        ecl_pkg::M_OUT: do_out = 1'b1;
        ecl_pkg::M_SLASH: begin
          if (c == ecl_pkg::CH_STAR) mode_nxt = ecl_pkg::M_BLOCK;
          else if (c == ecl_pkg::CH_SLASH) mode_nxt = ecl_pkg::M_LINE;
          else begin
            kv[n] = ecl_pkg::K_CHAR; vv[n] = ecl_pkg::CH_SLASH; n = 2'(n + 2'd1);
            mode_nxt = ecl_pkg::M_OUT;
            do_out   = 1'b1;
          end
        end
        ecl_pkg::M_BLOCK: begin
          if (c == ecl_pkg::CH_STAR) mode_nxt = ecl_pkg::M_BLOCK_STAR;
        end
        ecl_pkg::M_BLOCK_STAR: begin
          if (c == ecl_pkg::CH_SLASH) mode_nxt = ecl_pkg::M_OUT;
          else if (c != ecl_pkg::CH_STAR) mode_nxt = ecl_pkg::M_BLOCK;
        end
        ecl_pkg::M_LINE: begin
          if (c == ecl_pkg::CH_LF) mode_nxt = ecl_pkg::M_OUT;
        end
        ecl_pkg::M_STR: do_str = 1'b1;
        ecl_pkg::M_ESC: begin
          dv_nxt = 8'h00;
          dc_nxt = 2'd0;
          so_nxt = 1'b0;
          if (c >= ecl_pkg::CH_0 && c <= ecl_pkg::CH_7) begin
            dv_nxt   = {5'd0, c[2:0]};
            dc_nxt   = 2'd1;
            so_nxt   = (c > ecl_pkg::CH_3);
            mode_nxt = ecl_pkg::M_OCT;
          end else if (c == ecl_pkg::CH_X) begin
            mode_nxt = ecl_pkg::M_HEX;
          end else begin
            mode_nxt = ecl_pkg::M_STR;
            kv[n] = ecl_pkg::K_SBYTE;
            case (c)
              8'h61:            vv[n] = 8'd7;
              8'h62:            vv[n] = 8'd8;
              8'h74:            vv[n] = 8'd9;
              8'h6E:            vv[n] = 8'd10;
              8'h76:            vv[n] = 8'd11;
              8'h66:            vv[n] = 8'd12;
              8'h72:            vv[n] = 8'd13;
              ecl_pkg::CH_BSL:  vv[n] = ecl_pkg::CH_BSL;
              ecl_pkg::CH_QUOTE: vv[n] = ecl_pkg::CH_QUOTE;
              default: begin
                vv[n] = ecl_pkg::CH_BSL;
                n = 2'(n + 2'd1);
                kv[n] = ecl_pkg::K_SBYTE;
                vv[n] = c;
              end
            endcase
            n = 2'(n + 2'd1);
          end
        end
        ecl_pkg::M_OCT: begin
          if (c >= ecl_pkg::CH_0 && c <= ecl_pkg::CH_7 && dc_r < limit) begin
            acc = {dv_r[4:0], c[2:0]};
            if (cnt_inc >= limit) begin
              kv[n] = ecl_pkg::K_SBYTE; vv[n] = acc; n = 2'(n + 2'd1);
              dv_nxt = 8'h00; dc_nxt = 2'd0; so_nxt = 1'b0;
              mode_nxt = ecl_pkg::M_STR;
            end else begin
              dv_nxt = acc;
              dc_nxt = cnt_inc;
            end
          end else begin
            kv[n] = ecl_pkg::K_SBYTE; vv[n] = dv_r; n = 2'(n + 2'd1);
            dv_nxt = 8'h00; dc_nxt = 2'd0; so_nxt = 1'b0;
            mode_nxt = ecl_pkg::M_STR;
            do_str   = 1'b1;
          end
        end
        ecl_pkg::M_HEX: begin
          if (h[4] && dc_r < 2'd2) begin
            acc = {dv_r[3:0], h[3:0]};
            if (cnt_inc >= 2'd2) begin
              kv[n] = ecl_pkg::K_SBYTE; vv[n] = acc; n = 2'(n + 2'd1);
              dv_nxt = 8'h00; dc_nxt = 2'd0; so_nxt = 1'b0;
              mode_nxt = ecl_pkg::M_STR;
            end else begin
              dv_nxt = acc;
              dc_nxt = cnt_inc;
            end
          end else begin
            if (dc_r == 2'd0) begin
              kv[n] = ecl_pkg::K_SBYTE; vv[n] = ecl_pkg::CH_BSL; n = 2'(n + 2'd1);
              kv[n] = ecl_pkg::K_SBYTE; vv[n] = ecl_pkg::CH_X; n = 2'(n + 2'd1);
            end else begin
              kv[n] = ecl_pkg::K_SBYTE; vv[n] = dv_r; n = 2'(n + 2'd1);
            end
            dv_nxt = 8'h00; dc_nxt = 2'd0; so_nxt = 1'b0;
            mode_nxt = ecl_pkg::M_STR;
            do_str   = 1'b1;
          end
        end
        default: begin
          mode_nxt = ecl_pkg::M_OUT;
          dv_nxt = 8'h00; dc_nxt = 2'd0; so_nxt = 1'b0;
          do_out = 1'b1;
        end
      endcase
      if (do_out) begin
        if (c == ecl_pkg::CH_SPACE || (c >= 8'd9 && c <= 8'd13)) begin
          mode_nxt = ecl_pkg::M_OUT;
        end else if (c == ecl_pkg::CH_SLASH) begin
          mode_nxt = ecl_pkg::M_SLASH;
        end else if (c == ecl_pkg::CH_QUOTE) begin
          kv[n] = ecl_pkg::K_SSTART; n = 2'(n + 2'd1);
          mode_nxt = ecl_pkg::M_STR;
        end else begin
          kv[n] = ecl_pkg::K_CHAR; vv[n] = c; n = 2'(n + 2'd1);
        end
      end
      if (do_str) begin
        if (c == ecl_pkg::CH_QUOTE) begin
          kv[n] = ecl_pkg::K_SEND; n = 2'(n + 2'd1);
          mode_nxt = ecl_pkg::M_OUT;
        end else if (c == ecl_pkg::CH_BSL) begin
          mode_nxt = ecl_pkg::M_ESC;
        end else if (c == ecl_pkg::CH_LF) begin
          kv[n] = ecl_pkg::K_ERR; n = 2'(n + 2'd1);
          mode_nxt = ecl_pkg::M_OUT;
        end else begin
          kv[n] = ecl_pkg::K_SBYTE; vv[n] = c; n = 2'(n + 2'd1);
        end
      end
    end
    q_bundle.cnt   = n;
    q_bundle.kind  = kv;
    q_bundle.value = vv;
  end

  assign q_push = accept && (q_bundle.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ecl_pkg::M_OUT;
      dv_r   <= 8'h00;
      dc_r   <= 2'd0;
      so_r   <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      dv_r   <= dv_nxt;
      dc_r   <= dc_nxt;
      so_r   <= so_nxt;
    end
  end

endmodule

/* rtl/ecl_queue.sv */
// ----------------------------------------------------------------------------
// ecl_queue
// Small FIFO of result bundles between the lexer and the output stage.
// ----------------------------------------------------------------------------
module ecl_queue #(
  parameter int QDEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ecl_pkg::ecl_bundle_t push_data,
  output logic                 full,
  input  logic                 pop,
  output logic                 q_valid,
  output ecl_pkg::ecl_bundle_t head
);

  localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  ecl_pkg::ecl_bundle_t mem [QDEPTH];
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign head    = mem[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) wp_nxt = (wp_r == AW'(QDEPTH - 1)) ? '0 : AW'(wp_r + 1'b1);
    if (do_pop)  rp_nxt = (rp_r == AW'(QDEPTH - 1)) ? '0 : AW'(rp_r + 1'b1);
    if (do_push && !do_pop)      cnt_nxt = CW'(cnt_r + 1'b1);
    else if (do_pop && !do_push) cnt_nxt = CW'(cnt_r - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* rtl/ecl_back.sv */
// ----------------------------------------------------------------------------
// ecl_back
// Output stage: holds one bundle; sends one result per cycle while out_tready.
// ----------------------------------------------------------------------------
module ecl_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  ecl_pkg::ecl_bundle_t head,
  output logic                 pop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,
  output logic [2:0]           out_tuser,
  output logic                 out_tlast
);

  ecl_pkg::ecl_bundle_t cur_r;
  logic                 vld_r, vld_nxt;
  logic [1:0]           idx_r, idx_nxt;
  logic                 fin;

  assign out_tvalid = vld_r;
  assign out_tdata  = cur_r.value[idx_r];
  assign out_tuser  = cur_r.kind[idx_r];
  assign out_tlast  = (idx_r == 2'(cur_r.cnt - 2'd1));

  assign fin = vld_r && out_tready && out_tlast;
  assign pop = q_valid && (!vld_r || fin);

  always_comb begin
    vld_nxt = vld_r;
    idx_nxt = idx_r;
    if (pop) begin
      vld_nxt = 1'b1;
      idx_nxt = 2'd0;
    end else if (fin) begin
      vld_nxt = 1'b0;
    end else if (vld_r && out_tready) begin
      idx_nxt = 2'(idx_r + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur_r <= head;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= 2'd0;
    end else begin
      vld_r <= vld_nxt;
      idx_r <= idx_nxt;
    end
  end

endmodule

/* rtl/escape_and_comment_lexer.sv */
// ----------------------------------------------------------------------------
// escape_and_comment_lexer
// Byte-serial lexer: drops whitespace and comments, decodes string escapes.
// ----------------------------------------------------------------------------
// Input channel in_*: one request per byte; in_tuser high marks end of input
// (in_tdata ignored). Output channel out_*: tokens, out_tuser = kind,
// out_tdata = character or decoded byte, out_tlast on the final token of
// each request. A request makes zero to three tokens.
// The bundle of an accepted request is registered in the queue and is then
// loaded into the output stage, which presents its first token.
// Throughput: one byte per cycle while the receiver is ready and each byte
// makes at most one token; longer requests hold the output until all are sent.
// The lexer runs ahead through a QDEPTH-entry bundle queue; in_tready drops
// only when that queue is full, so a stalled receiver backs up the input
// after QDEPTH pending bundles plus the one being sent.
// Reset (rst_n low, synchronous): lexer outside strings, queue and output
// empty. End of input also returns the lexer to that state.
// ----------------------------------------------------------------------------
module escape_and_comment_lexer #(
  parameter int QDEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] byte_in
  input  logic       in_tuser,   // [0] func
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] value
  output logic [2:0] out_tuser,  // [2:0] kind
  output logic       out_tlast
);

  ecl_pkg::ecl_bundle_t push_data, head;
  logic                 push, full, pop, q_valid;

  ecl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (full),
    .q_push    (push),
    .q_bundle  (push_data)
  );

  ecl_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .q_valid   (q_valid),
    .head      (head)
  );

  ecl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for escape_and_comment_lexer.
// A short table of directed bytes runs first, then random text built from
// comments, strings with escapes and stray bytes. Each accepted request goes
// through a local lexer model; tokens are compared in order at the output.
// Both stream sides idle at random, with one long receiver hold.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct packed {
    logic       func;
    logic [7:0] data;
    logic       typed;
    logic [1:0] n;
    logic [2:0] k0;
    logic [7:0] v0;
    logic [2:0] k1;
    logic [7:0] v1;
  } lex_req_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic       last;
  } token_t;

  localparam int DIR_N      = 28;
  localparam int RAND_ITEMS = 222;
  localparam int HOLD_AT    = DIR_N + 80;
  localparam int DRAIN_AT   = DIR_N + 180;

  localparam lex_req_t DIR_TABLE [DIR_N] = '{
    '{1'b0, "A", 1'b1, 2'd1, ecl_pkg::K_CHAR, "A", ecl_pkg::K_CHAR, 8'h00},
    '{1'b0, 8'hFF, 1'b1, 2'd1, ecl_pkg::K_CHAR, 8'hFF, ecl_pkg::K_CHAR, 8'h00},
    '{1'b0, 8'h00, 1'b1, 2'd1, ecl_pkg::K_CHAR, 8'h00, ecl_pkg::K_CHAR, 8'h00},
    '{1'b0, ecl_pkg::CH_SLASH, 1'b1, 2'd0, ecl_pkg::K_CHAR, 8'h00, ecl_pkg::K_CHAR, 8'h00},
    '{1'b0, "q", 1'b1, 2'd2, ecl_pkg::K_CHAR, ecl_pkg::CH_SLASH,
      ecl_pkg::K_CHAR, "q"},
    '{1'b0, ecl_pkg::CH_SLASH, 1'b0, 2'd0, ecl_pkg::K_CHAR, 8'h00, ecl_pkg::K_CHAR, 8'h00},
    '{1'b0, ecl_pkg::CH_STAR, 1'b0, 2'd0, ecl_pkg::K_CHAR, 8'h00, ecl_pkg::K_CHAR, 8'h00},
    '{1'b0, ecl_pkg::CH_STAR, 1'b0, 2'd0, ecl_pkg::K_CHAR, 8'h00, ecl_pkg::K_CHAR, 8'h00},
    '{1'b0, ecl_pkg::CH_STAR, 1'b0, 2'd0, ecl_pkg::K_CHAR, 8'h00, ecl_pkg::K_CHAR, 8'h00},
    '{1'b0, ecl_pkg::CH_SLASH, 1'b0, 2'd0, ecl_pkg::K_CHAR, 8'h00, ecl_pkg::K_CHAR, 8'h00},
    '{1'b0, ecl_pkg::CH_SLASH, 1'b0, 2'd0, ecl_pkg::K_CHAR, 8'h00, ecl_pkg::K_CHAR, 8'h00},
    '{1'b1, 8'hA5, 1'b1, 2'd2, ecl_pkg::K_CHAR, ecl_pkg::CH_SLASH,
      ecl_pkg::K_END, 8'h00},
    '{1'b0, ecl_pkg::CH_QUOTE, 1'b1, 2'd1, ecl_pkg::K_SSTART, 8'h00,
      ecl_pkg::K_CHAR, 8'h00},
    '{1'b0, ecl_pkg::CH_BSL, 1'b0, 2'd0, ecl_pkg::K_CHAR, 8'h00, ecl_pkg::K_CHAR, 8'h00},
    '{1'b0, "4", 1'b0, 2'd0, ecl_pkg::K_CHAR, 8'h00, ecl_pkg::K_CHAR, 8'h00},
    '{1'b0, ecl_pkg::CH_7, 1'b0, 2'd0, ecl_pkg::K_CHAR, 8'h00, ecl_pkg::K_CHAR, 8'h00},
    '{1'b0, ecl_pkg::CH_BSL, 1'b0, 2'd0, ecl_pkg::K_CHAR, 8'h00, ecl_pkg::K_CHAR, 8'h00},
    '{1'b0, ecl_pkg::CH_X, 1'b0, 2'd0, ecl_pkg::K_CHAR, 8'h00, ecl_pkg::K_CHAR, 8'h00},
    '{1'b0, ecl_pkg::CH_QUOTE, 1'b0, 2'd0, ecl_pkg::K_CHAR, 8'h00, ecl_pkg::K_CHAR, 8'h00},
    '{1'b0, ecl_pkg::CH_QUOTE, 1'b0, 2'd0, ecl_pkg::K_CHAR, 8'h00, ecl_pkg::K_CHAR, 8'h00},
    '{1'b0, ecl_pkg::CH_BSL, 1'b0, 2'd0, ecl_pkg::K_CHAR, 8'h00, ecl_pkg::K_CHAR, 8'h00},
    '{1'b0, ecl_pkg::CH_LF, 1'b0, 2'd0, ecl_pkg::K_CHAR, 8'h00, ecl_pkg::K_CHAR, 8'h00},
    '{1'b0, ecl_pkg::CH_LF, 1'b1, 2'd1, ecl_pkg::K_ERR, 8'h00, ecl_pkg::K_CHAR, 8'h00},
    '{1'b0, ecl_pkg::CH_SLASH, 1'b0, 2'd0, ecl_pkg::K_CHAR, 8'h00, ecl_pkg::K_CHAR, 8'h00},
    '{1'b0, ecl_pkg::CH_STAR, 1'b0, 2'd0, ecl_pkg::K_CHAR, 8'h00, ecl_pkg::K_CHAR, 8'h00},
    '{1'b1, 8'h5A, 1'b1, 2'd1, ecl_pkg::K_END, 8'h00, ecl_pkg::K_CHAR, 8'h00},
    '{1'b0, ecl_pkg::CH_QUOTE, 1'b1, 2'd1, ecl_pkg::K_SSTART, 8'h00,
      ecl_pkg::K_CHAR, 8'h00},
    '{1'b1, 8'hFF, 1'b1, 2'd1, ecl_pkg::K_ERR, 8'h00, ecl_pkg::K_CHAR, 8'h00}
  };

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       in_tuser;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic [2:0] out_tuser;
  logic       out_tlast;

  lex_req_t   req_q[$];
  token_t     step_tokens[$];
  token_t     pending_tokens[$];
  int         n_req;
  int         n_err;

  ecl_pkg::lex_mode_t lex_st;
  logic [7:0]         esc_val;
  logic [1:0]         esc_cnt;
  logic               esc_short;

  escape_and_comment_lexer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("TEST FAILED");
    $finish;
  end

  // ---- lexer model ----
  function automatic void emit(logic [2:0] kind, logic [7:0] value);
    token_t t;
    t.kind  = kind;
    t.value = value;
    t.last  = 1'b0;
    step_tokens.push_back(t);
  endfunction

  function automatic void clear_escape();
    esc_val   = 8'h00;
    esc_cnt   = 2'd0;
    esc_short = 1'b0;
  endfunction

  function automatic bit is_space(logic [7:0] c);
    return c == ecl_pkg::CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic int hex_digit(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic void lex_outside(logic [7:0] c);
    if (is_space(c)) return;
    if (c == ecl_pkg::CH_SLASH) begin
      lex_st = ecl_pkg::M_SLASH;
      return;
    end
    if (c == ecl_pkg::CH_QUOTE) begin
      emit(ecl_pkg::K_SSTART, 8'h00);
      lex_st = ecl_pkg::M_STR;
      return;
    end
    emit(ecl_pkg::K_CHAR, c);
  endfunction

  function automatic void lex_string(logic [7:0] c);
    if (c == ecl_pkg::CH_QUOTE) begin
      emit(ecl_pkg::K_SEND, 8'h00);
      lex_st = ecl_pkg::M_OUT;
    end else if (c == ecl_pkg::CH_BSL) begin
      lex_st = ecl_pkg::M_ESC;
    end else if (c == ecl_pkg::CH_LF) begin
      emit(ecl_pkg::K_ERR, 8'h00);
      lex_st = ecl_pkg::M_OUT;
    end else begin
      emit(ecl_pkg::K_SBYTE, c);
    end
  endfunction

  function automatic void lex_escape(logic [7:0] c);
    logic [7:0] b;
    clear_escape();
    if (c >= ecl_pkg::CH_0 && c <= ecl_pkg::CH_7) begin
      esc_val   = {5'd0, c[2:0]};
      esc_cnt   = 2'd1;
      esc_short = c > ecl_pkg::CH_3;
      lex_st    = ecl_pkg::M_OCT;
      return;
    end
    if (c == ecl_pkg::CH_X) begin
      lex_st = ecl_pkg::M_HEX;
      return;
    end
    lex_st = ecl_pkg::M_STR;
    case (c)
      "a":               b = 8'h07;
      "b":               b = 8'h08;
      "t":               b = 8'h09;
      "n":               b = 8'h0A;
      "v":               b = 8'h0B;
      "f":               b = 8'h0C;
      "r":               b = 8'h0D;
      ecl_pkg::CH_BSL:   b = ecl_pkg::CH_BSL;
      ecl_pkg::CH_QUOTE: b = ecl_pkg::CH_QUOTE;
      default: begin
        emit(ecl_pkg::K_SBYTE, ecl_pkg::CH_BSL);
        emit(ecl_pkg::K_SBYTE, c);
        return;
      end
    endcase
    emit(ecl_pkg::K_SBYTE, b);
  endfunction

  // flush a pending hex or octal escape ahead of an ending byte
  function automatic void flush_digits(bit is_hex);
    if (is_hex && esc_cnt == 2'd0) begin
      emit(ecl_pkg::K_SBYTE, ecl_pkg::CH_BSL);
      emit(ecl_pkg::K_SBYTE, ecl_pkg::CH_X);
    end else begin
      emit(ecl_pkg::K_SBYTE, esc_val);
    end
    clear_escape();
  endfunction

  function automatic void lex_data(logic [7:0] c);
    int limit;
    int h;
    case (lex_st)
      ecl_pkg::M_OUT: lex_outside(c);
      ecl_pkg::M_SLASH: begin
        if (c == ecl_pkg::CH_STAR) lex_st = ecl_pkg::M_BLOCK;
        else if (c == ecl_pkg::CH_SLASH) lex_st = ecl_pkg::M_LINE;
        else begin
          emit(ecl_pkg::K_CHAR, ecl_pkg::CH_SLASH);
          lex_st = ecl_pkg::M_OUT;
          lex_outside(c);
        end
      end
      ecl_pkg::M_BLOCK: if (c == ecl_pkg::CH_STAR) lex_st = ecl_pkg::M_BLOCK_STAR;
      ecl_pkg::M_BLOCK_STAR: begin
        if (c == ecl_pkg::CH_SLASH) lex_st = ecl_pkg::M_OUT;
        else if (c != ecl_pkg::CH_STAR) lex_st = ecl_pkg::M_BLOCK;
      end
      ecl_pkg::M_LINE: if (c == ecl_pkg::CH_LF) lex_st = ecl_pkg::M_OUT;
      ecl_pkg::M_STR: lex_string(c);
      ecl_pkg::M_ESC: lex_escape(c);
      ecl_pkg::M_OCT: begin
        limit = esc_short ? 2 : 3;
        if (c >= ecl_pkg::CH_0 && c <= ecl_pkg::CH_7 && esc_cnt < limit) begin
          esc_val = {esc_val[4:0], c[2:0]};
          esc_cnt = esc_cnt + 2'd1;
          if (esc_cnt >= limit) begin
            emit(ecl_pkg::K_SBYTE, esc_val);
            clear_escape();
            lex_st = ecl_pkg::M_STR;
          end
        end else begin
          flush_digits(1'b0);
          lex_st = ecl_pkg::M_STR;
          lex_string(c);
        end
      end
      ecl_pkg::M_HEX: begin
        h = hex_digit(c);
        if (h >= 0 && esc_cnt < 2'd2) begin
          esc_val = {esc_val[3:0], 4'(h)};
          esc_cnt = esc_cnt + 2'd1;
          if (esc_cnt >= 2'd2) begin
            emit(ecl_pkg::K_SBYTE, esc_val);
            clear_escape();
            lex_st = ecl_pkg::M_STR;
          end
        end else begin
          flush_digits(1'b1);
          lex_st = ecl_pkg::M_STR;
          lex_string(c);
        end
      end
      default: begin
        lex_st = ecl_pkg::M_OUT;
        clear_escape();
        lex_outside(c);
      end
    endcase
  endfunction

  function automatic void lex_end();
    case (lex_st)
      ecl_pkg::M_SLASH: begin
        emit(ecl_pkg::K_CHAR, ecl_pkg::CH_SLASH);
        emit(ecl_pkg::K_END, 8'h00);
      end
      ecl_pkg::M_STR: emit(ecl_pkg::K_ERR, 8'h00);
      ecl_pkg::M_ESC: begin
        emit(ecl_pkg::K_SBYTE, ecl_pkg::CH_BSL);
        emit(ecl_pkg::K_ERR, 8'h00);
      end
      ecl_pkg::M_OCT: begin
        flush_digits(1'b0);
        emit(ecl_pkg::K_ERR, 8'h00);
      end
      ecl_pkg::M_HEX: begin
        flush_digits(1'b1);
        emit(ecl_pkg::K_ERR, 8'h00);
      end
      default: emit(ecl_pkg::K_END, 8'h00);
    endcase
    lex_st = ecl_pkg::M_OUT;
    clear_escape();
  endfunction

  function automatic void lex_request(logic func, logic [7:0] data);
    step_tokens.delete();
    if (func) lex_end();
    else lex_data(data);
  endfunction

  // ---- stimulus ----
  function automatic void add_req(logic func, logic [7:0] data);
    lex_req_t r;
    r = '0;
    r.func = func;
    r.data = data;
    req_q.push_back(r);
  endfunction

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  initial begin : driver
    string      named_esc;
    string      hex_chars;
    string      ws_chars;
    lex_req_t   r;
    logic [7:0] b;
    int         gap;
    int         burst;
    bit         drain;

    named_esc = "abtnvfr\\\"";
    hex_chars = "0123456789abcdefABCDEF";
    ws_chars  = " \t\n\v\f\r";
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'h00;
    in_tuser  <= 1'b0;
    n_req = 0;
    n_err = 0;
    burst = 0;
    lex_st = ecl_pkg::M_OUT;
    clear_escape();

    foreach (DIR_TABLE[j]) req_q.push_back(DIR_TABLE[j]);
    while (req_q.size() < DIR_N + RAND_ITEMS) begin
      case ($urandom_range(0, 15))
        0, 1, 15: add_req(1'b0, 8'($urandom_range(0, 255)));
        2: add_req(1'b0, ws_chars[$urandom_range(0, 5)]);
        3, 4: add_req(1'b0, 8'($urandom_range(33, 126)));
        5, 6: begin
          add_req(1'b0, ecl_pkg::CH_SLASH);
          add_req(1'b0, ecl_pkg::CH_STAR);
          repeat ($urandom_range(0, 6))
            add_req(1'b0, ($urandom_range(0, 3) == 0) ? ecl_pkg::CH_STAR
                                                      : 8'($urandom_range(0, 255)));
          repeat ($urandom_range(1, 3)) add_req(1'b0, ecl_pkg::CH_STAR);
          add_req(1'b0, ecl_pkg::CH_SLASH);
        end
        7: begin
          add_req(1'b0, ecl_pkg::CH_SLASH);
          add_req(1'b0, ecl_pkg::CH_SLASH);
          repeat ($urandom_range(0, 6)) add_req(1'b0, 8'($urandom_range(0, 255)));
          add_req(1'b0, ecl_pkg::CH_LF);
        end
        8: begin
          add_req(1'b0, ecl_pkg::CH_SLASH);
          add_req(1'b0, 8'($urandom_range(0, 255)));
        end
        14: add_req(1'b1, 8'($urandom_range(0, 255)));
        default: begin
          add_req(1'b0, ecl_pkg::CH_QUOTE);
          repeat ($urandom_range(0, 5)) begin
            case ($urandom_range(0, 6))
              0: begin
                b = 8'($urandom_range(0, 255));
                if (b == ecl_pkg::CH_QUOTE || b == ecl_pkg::CH_BSL || b == ecl_pkg::CH_LF)
                  b = "s";
                add_req(1'b0, b);
              end
              1: begin
                add_req(1'b0, ecl_pkg::CH_BSL);
                add_req(1'b0, named_esc[$urandom_range(0, 8)]);
              end
              2: begin
                add_req(1'b0, ecl_pkg::CH_BSL);
                repeat ($urandom_range(1, 3))
                  add_req(1'b0, 8'(ecl_pkg::CH_0 + $urandom_range(0, 7)));
              end
              3: begin
                add_req(1'b0, ecl_pkg::CH_BSL);
                add_req(1'b0, ecl_pkg::CH_X);
                repeat ($urandom_range(0, 2)) add_req(1'b0, hex_chars[$urandom_range(0, 21)]);
              end
              4: begin
                add_req(1'b0, ecl_pkg::CH_BSL);
                add_req(1'b0, 8'($urandom_range(0, 255)));
              end
              5: add_req(1'b0, ecl_pkg::CH_BSL);
              default: add_req(1'b0, 8'($urandom_range(32, 126)));
            endcase
          end
          case ($urandom_range(0, 9))
            0: add_req(1'b0, ecl_pkg::CH_LF);
            1: add_req(1'b1, 8'($urandom_range(0, 255)));
            default: add_req(1'b0, ecl_pkg::CH_QUOTE);
          endcase
        end
      endcase
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < req_q.size(); i++) begin
      r = req_q[i];
      if (burst > 0) begin
        gap = 0;
        burst--;
      end else begin
        gap = idle_gap();
        if ($urandom_range(0, 19) == 0) burst = $urandom_range(15, 40);
      end
      drain = (i == DIR_N || i == DRAIN_AT);
      if (gap > 0 || drain) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
        if (drain) begin
          @(posedge clk);
          while (pending_tokens.size() != 0) @(posedge clk);
        end
      end
      in_tvalid <= 1'b1;
      in_tuser  <= r.func;
      in_tdata  <= r.data;
      do @(posedge clk); while (in_tready !== 1'b1);

      lex_request(r.func, r.data);
      if (r.typed) begin
        step_tokens.delete();
        if (r.n > 2'd0) emit(r.k0, r.v0);
        if (r.n > 2'd1) emit(r.k1, r.v1);
      end
      if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
      foreach (step_tokens[k]) pending_tokens.push_back(step_tokens[k]);
      n_req++;
    end
    in_tvalid <= 1'b0;

    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (n_err == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // ---- receiver ----
  initial begin : sink
    int  n;
    bit  held;
    held = 1'b0;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      // long hold to back the lexer up into its input
      if (!held && n_req >= HOLD_AT) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (100) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 25)) @(posedge clk);
      n = idle_gap();
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_tokens
    token_t want;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      if (pending_tokens.size() == 0) begin
        $error("token with none pending: kind %0d value %0h", out_tuser, out_tdata);
        n_err++;
      end else begin
        want = pending_tokens.pop_front();
        if (out_tuser !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_tuser);
          n_err++;
        end
        if (out_tdata !== want.value) begin
          $error("value: expected %0h, got %0h", want.value, out_tdata);
          n_err++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_tlast);
          n_err++;
        end
      end
    end
  end

endmodule
